[hw/rtl/haqs_pkg.sv]
package haqs_pkg;

	// Result codes of one event.
	typedef enum logic [2:0] {
		OUTCOME_STARTED   = 3'd0,
		OUTCOME_QUEUED    = 3'd1,
		OUTCOME_CONG_DROP = 3'd2,
		OUTCOME_CAP_DROP  = 3'd3,
		OUTCOME_COMPLETED = 3'd4,
		OUTCOME_NO_JOB    = 3'd5
	} outcome_t;

	// Event kinds.
	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_END     = 1'b1;

	// Configuration port geometry and register indexes.
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 7;

	localparam logic [CfgIdxW-1:0] CFG_FIFO_ORDER     = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_STOP_THRESHOLD = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_RESTART_THRESH = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_CAP_ENABLE     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_CAP_LIMIT      = 3'd4;

	// Fixed field widths.
	localparam int PortTagW = 16;
	localparam int CountW   = 7;

	typedef struct packed {
		logic                operation;
		logic [PortTagW-1:0] job_tag;
	} haqs_in_t;

	typedef struct packed {
		outcome_t            outcome;
		logic [PortTagW-1:0] departed_tag;
		logic                next_valid;
		logic [PortTagW-1:0] next_tag;
		logic [CountW-1:0]   queue_count;
		logic                server_busy;
		logic                congested;
	} haqs_out_t;

endpackage

[hw/rtl/haqs_ram.sv]
// Ring store: one write port and one read port with registered read data.
// The read register only loads when rd_en is high, so it holds while the
// stage that consumes it is stalled.
module haqs_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/hysteresis_admission_queue_server_unit.sv]
// Single-server job queue with hysteresis admission control. Each request is a
// job arrival or an end-of-service event and yields exactly one result. The unit
// takes one request per clock cycle when the output is not stalled. A request
// loads the input register at acceptance, then the ring store read register and
// second stage registers, then the output register that holds its result. Up to
// QUEUE_DEPTH jobs wait besides the job in service; they are served oldest first
// or newest first as fifo_order selects. Configuration is to be written by the
// user only while no request is in flight; the unit itself does not enforce this.
module hysteresis_admission_queue_server_unit #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TAG_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [haqs_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [haqs_pkg::CfgDataW-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  haqs_pkg::haqs_in_t              in_req,
	output logic                            out_valid,
	input  logic                            out_stall,
	output haqs_pkg::haqs_out_t             out_rsp
);

	localparam int AddrW  = $clog2(QUEUE_DEPTH);
	localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
	localparam int SumW   = CntW + 1;
	localparam int CmpW   = (CntW > haqs_pkg::CountW) ? CntW : haqs_pkg::CountW;
	localparam int KeepW  = (TAG_BITS < haqs_pkg::PortTagW) ? TAG_BITS : haqs_pkg::PortTagW;

	// Configuration registers.
	logic                         fifo_order_q;
	logic [haqs_pkg::CountW-1:0]  stop_thr_q;
	logic [haqs_pkg::CountW-1:0]  restart_thr_q;
	logic                         cap_en_q;
	logic [haqs_pkg::CountW-1:0]  cap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_order_q  <= 1'b1;
			stop_thr_q    <= 7'd48;
			restart_thr_q <= 7'd16;
			cap_en_q      <= 1'b0;
			cap_limit_q   <= 7'd64;
		end else if (cfg_write) begin
			unique case (cfg_index)
				haqs_pkg::CFG_FIFO_ORDER:     fifo_order_q  <= cfg_data[0];
				haqs_pkg::CFG_STOP_THRESHOLD: stop_thr_q    <= cfg_data;
				haqs_pkg::CFG_RESTART_THRESH: restart_thr_q <= cfg_data;
				haqs_pkg::CFG_CAP_ENABLE:     cap_en_q      <= cfg_data[0];
				haqs_pkg::CFG_CAP_LIMIT:      cap_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control: each stage advances when the one after it frees.
	logic v_s1, v_s2, out_valid_q;
	logic out_ready, s2_free, s1_free, mv1, mv2;

	assign out_ready = !out_valid_q || !out_stall;
	assign mv2       = v_s2 && out_ready;
	assign s2_free   = !v_s2 || out_ready;
	assign mv1       = v_s1 && s2_free;
	assign s1_free   = !v_s1 || s2_free;
	assign in_stall  = !s1_free;

	// Input register.
	haqs_pkg::haqs_in_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			req_s1 <= in_req;
		end
	end

	// Queue control state.
	logic [AddrW-1:0] head_q;
	logic [CntW-1:0]  count_q;
	logic             busy_q;
	logic             cong_q;

	// Decision for the request in the first stage.
	logic [TAG_BITS-1:0]  tag_s1;
	logic [CmpW-1:0]      count_cmp;
	logic [SumW-1:0]      tail_sum, last_sum;
	logic [AddrW-1:0]     wr_pos, last_pos, head_inc;
	haqs_pkg::outcome_t   outcome_d;
	logic                 next_valid_d, busy_d, cong_d, wr_en_d;
	logic [CntW-1:0]      count_d;
	logic [AddrW-1:0]     head_d, rd_pos_d;

	assign tag_s1    = TAG_BITS'(req_s1.job_tag[KeepW-1:0]);
	assign count_cmp = CmpW'(count_q);

	// Ring positions: the sum stays below twice the depth, so one subtract wraps it.
	always_comb begin
		tail_sum = SumW'(head_q) + SumW'(count_q);
		last_sum = tail_sum - SumW'(1);
		wr_pos   = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
			AddrW'(tail_sum - SumW'(QUEUE_DEPTH)) : AddrW'(tail_sum);
		last_pos = (last_sum >= SumW'(QUEUE_DEPTH)) ?
			AddrW'(last_sum - SumW'(QUEUE_DEPTH)) : AddrW'(last_sum);
		head_inc = (SumW'(head_q) == SumW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AddrW'(1);
	end

	// Admission and service decision.
	always_comb begin
		outcome_d    = haqs_pkg::OUTCOME_NO_JOB;
		next_valid_d = 1'b0;
		busy_d       = busy_q;
		cong_d       = cong_q;
		count_d      = count_q;
		head_d       = head_q;
		wr_en_d      = 1'b0;
		rd_pos_d     = fifo_order_q ? head_q : last_pos;
		if (req_s1.operation == haqs_pkg::OP_ARRIVAL) begin
			if (!busy_q) begin
				busy_d    = 1'b1;
				outcome_d = haqs_pkg::OUTCOME_STARTED;
			end else if (cong_q && count_cmp > CmpW'(restart_thr_q)) begin
				outcome_d = haqs_pkg::OUTCOME_CONG_DROP;
			end else if (!cong_q && count_cmp >= CmpW'(stop_thr_q)) begin
				cong_d    = 1'b1;
				outcome_d = haqs_pkg::OUTCOME_CONG_DROP;
			end else begin
				// Congestion, if set, clears here even when capacity then drops the job.
				cong_d = 1'b0;
				if ((cap_en_q && count_cmp >= CmpW'(cap_limit_q)) ||
				    count_q >= CntW'(QUEUE_DEPTH)) begin
					outcome_d = haqs_pkg::OUTCOME_CAP_DROP;
				end else begin
					outcome_d = haqs_pkg::OUTCOME_QUEUED;
					wr_en_d   = 1'b1;
					count_d   = count_q + CntW'(1);
				end
			end
		end else if (busy_q) begin
			outcome_d = haqs_pkg::OUTCOME_COMPLETED;
			if (count_q == '0) begin
				busy_d = 1'b0;
			end else begin
				next_valid_d = 1'b1;
				count_d      = count_q - CntW'(1);
				if (fifo_order_q) begin
					head_d = head_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			cong_q  <= 1'b0;
		end else if (mv1) begin
			head_q  <= head_d;
			count_q <= count_d;
			busy_q  <= busy_d;
			cong_q  <= cong_d;
		end
	end

	// Job store; the read lands together with the request in the second stage.
	logic [TAG_BITS-1:0] rd_tag;

	haqs_ram #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W (TAG_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (mv1 && wr_en_d),
		.wr_addr (wr_pos),
		.wr_data (tag_s1),
		.rd_en   (mv1),
		.rd_addr (rd_pos_d),
		.rd_data (rd_tag)
	);

	// Second stage registers.
	haqs_pkg::outcome_t          outcome_s2;
	logic [TAG_BITS-1:0]         tag_s2;
	logic                        next_valid_s2, busy_s2, cong_s2;
	logic [haqs_pkg::CountW-1:0] count_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			outcome_s2    <= outcome_d;
			tag_s2        <= tag_s1;
			next_valid_s2 <= next_valid_d;
			busy_s2       <= busy_d;
			cong_s2       <= cong_d;
			count_s2      <= haqs_pkg::CountW'(count_d);
		end
	end

	// Tag of the job in service, updated as each result leaves the second stage.
	logic [TAG_BITS-1:0] serving_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serving_q <= '0;
		end else if (mv2) begin
			if (outcome_s2 == haqs_pkg::OUTCOME_STARTED) begin
				serving_q <= tag_s2;
			end else if (next_valid_s2) begin
				serving_q <= rd_tag;
			end
		end
	end

	// Result assembly.
	haqs_pkg::haqs_out_t rsp_d, out_rsp_q;

	always_comb begin
		rsp_d.outcome      = outcome_s2;
		rsp_d.departed_tag = (outcome_s2 == haqs_pkg::OUTCOME_COMPLETED) ?
			haqs_pkg::PortTagW'(serving_q[KeepW-1:0]) : '0;
		rsp_d.next_valid   = next_valid_s2;
		rsp_d.next_tag     = next_valid_s2 ?
			haqs_pkg::PortTagW'(rd_tag[KeepW-1:0]) : '0;
		rsp_d.queue_count  = count_s2;
		rsp_d.server_busy  = busy_s2;
		rsp_d.congested    = cong_s2;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			out_rsp_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// The queue never holds more jobs than the store has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("queue count exceeds store depth");

	// Jobs only wait while another job is in service.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> count_q == '0)
		else $error("jobs queued while server idle");

	// A queued arrival grows the queue by exactly one.
	a_queue_grow: assert property (@(posedge clk) disable iff (!arst_n)
		mv1 && wr_en_d |=> count_q == $past(count_q) + CntW'(1))
		else $error("queued arrival did not grow the queue");

	// A job only enters service from the queue on completion.
	a_next_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_rsp_q.next_valid |->
			out_rsp_q.outcome == haqs_pkg::OUTCOME_COMPLETED)
		else $error("next job without completion");

endmodule
